// ===== rtl/core/cpcr_pkg.sv =====
package cpcr_pkg;

   localparam logic [16:0] OneQ16 = 17'd65536;

   // cycles from an accepted request to its result strobe
   localparam int unsigned FrontStages = 4;
   localparam int unsigned SqrtSteps = 25;
   localparam int unsigned DivSteps = 17;
   localparam int unsigned BackStages = 9;
   localparam int unsigned Latency = FrontStages + SqrtSteps + DivSteps + BackStages;

   typedef enum logic [2:0] {
      CSR_SEP    = 3'd0,
      CSR_REST   = 3'd1,
      CSR_XFER   = 3'd2,
      CSR_MAXI   = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } cpcr_csr_type;

   typedef struct packed {
      logic [16:0] sep;
      logic [16:0] rest;
      logic [16:0] xfer;
      logic [30:0] maxi;
      logic [30:0] width;
      logic [30:0] height;
   } cpcr_cfg_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic [23:0]        ra;
      logic [23:0]        rb;
      logic signed [31:0] avx;
      logic signed [31:0] avy;
      logic signed [31:0] bvx;
      logic signed [31:0] bvy;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [24:0]        rsum;
      logic               hit;
   } cpcr_pair_type;

   // signed divide by 2**sh, rounding toward zero
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                    input int unsigned sh);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (v + bias) >>> sh;
   endfunction

   // max(r, min(hi, p)): the lower bound wins on an inverted box
   function automatic logic [31:0] clamp_box(input logic signed [33:0] p,
                                             input logic signed [32:0] hi,
                                             input logic [23:0] r);
      logic signed [33:0] m;
      logic signed [33:0] lo;
      lo = $signed({10'b0, r});
      m = (p > 34'(hi)) ? 34'(hi) : p;
      if (m < lo) begin
         m = lo;
      end
      return m[31:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cpcr_front.sv =====
module cpcr_front import cpcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  cpcr_pair_type in_pair,
   output logic          out_vld,
   output cpcr_pair_type out_pair,
   output logic [49:0]   out_d2
);

   logic          p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   cpcr_pair_type p1_pair_in, p4_pair_in;
   cpcr_pair_type p1_pair_ff, p2_pair_ff, p3_pair_ff, p4_pair_ff;
   logic          p2_near_ff, p3_near_ff;
   logic [24:0]   p2_adx_ff, p2_ady_ff;
   logic [49:0]   p3_sqx_ff, p3_sqy_ff, p3_rs2_ff;
   logic [49:0]   p4_d2_ff;
   logic [32:0]   adx, ady;
   logic [50:0]   d2_sum;

   always_comb begin
      p1_pair_in = in_pair;
      p1_pair_in.dx = 33'(in_pair.bx) - 33'(in_pair.ax);
      p1_pair_in.dy = 33'(in_pair.by) - 33'(in_pair.ay);
      p1_pair_in.rsum = {1'b0, in_pair.ra} + {1'b0, in_pair.rb};
      p1_pair_in.hit = 1'b0;
   end

   assign adx = p1_pair_ff.dx[32] ? 33'(-p1_pair_ff.dx) : p1_pair_ff.dx;
   assign ady = p1_pair_ff.dy[32] ? 33'(-p1_pair_ff.dy) : p1_pair_ff.dy;
   assign d2_sum = {1'b0, p3_sqx_ff} + {1'b0, p3_sqy_ff};

   always_comb begin
      p4_pair_in     = p3_pair_ff;
      p4_pair_in.hit = p3_near_ff && (d2_sum < {1'b0, p3_rs2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= in_vld;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_pair_ff <= p1_pair_in;

      p2_pair_ff <= p1_pair_ff;
      p2_near_ff <= (adx < {8'b0, p1_pair_ff.rsum}) && (ady < {8'b0, p1_pair_ff.rsum});
      p2_adx_ff  <= adx[24:0];
      p2_ady_ff  <= ady[24:0];

      p3_pair_ff <= p2_pair_ff;
      p3_near_ff <= p2_near_ff;
      p3_sqx_ff  <= 50'(p2_adx_ff) * 50'(p2_adx_ff);
      p3_sqy_ff  <= 50'(p2_ady_ff) * 50'(p2_ady_ff);
      p3_rs2_ff  <= 50'(p2_pair_ff.rsum) * 50'(p2_pair_ff.rsum);

      p4_pair_ff <= p4_pair_in;
      p4_d2_ff   <= d2_sum[49:0];
   end

   assign out_vld  = p4_vld_ff;
   assign out_pair = p4_pair_ff;
   assign out_d2   = p4_d2_ff;

endmodule

// ===== rtl/core/cpcr_sqrt.sv =====
module cpcr_sqrt import cpcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  cpcr_pair_type in_pair,
   input  logic [49:0]   in_d2,
   output logic          out_vld,
   output cpcr_pair_type out_pair,
   output logic [24:0]   out_d
);

   logic          vld_ff  [0:SqrtSteps-1];
   cpcr_pair_type pair_ff [0:SqrtSteps-1];
   logic [49:0]   rem_ff  [0:SqrtSteps-1];
   logic [24:0]   root_ff [0:SqrtSteps-1];

   // one result bit per stage, most significant first
   for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
      localparam int unsigned K = SqrtSteps - 1 - s;
      logic          vld_prev;
      cpcr_pair_type pair_prev;
      logic [49:0]   rem_prev;
      logic [24:0]   root_prev;
      logic [50:0]   trial;
      logic          take;

      if (s == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign pair_prev = in_pair;
         assign rem_prev  = in_d2;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign pair_prev = pair_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      assign trial = (51'(root_prev) << (K + 1)) + (51'd1 << (2 * K));
      assign take  = {1'b0, rem_prev} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         pair_ff[s] <= pair_prev;
         rem_ff[s]  <= take ? 50'({1'b0, rem_prev} - trial) : rem_prev;
         root_ff[s] <= take ? (root_prev | (25'd1 << K)) : root_prev;
      end
   end

   assign out_vld  = vld_ff[SqrtSteps-1];
   assign out_pair = pair_ff[SqrtSteps-1];
   assign out_d    = root_ff[SqrtSteps-1];

endmodule

// ===== rtl/core/cpcr_div.sv =====
module cpcr_div import cpcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  cpcr_pair_type      in_pair,
   input  logic [24:0]        in_d,
   output logic               out_vld,
   output cpcr_pair_type      out_pair,
   output logic [24:0]        out_d,
   output logic signed [17:0] out_nx,
   output logic signed [17:0] out_ny
);

   logic          vld_ff  [0:DivSteps-1];
   cpcr_pair_type pair_ff [0:DivSteps-1];
   logic [24:0]   d_ff    [0:DivSteps-1];
   logic [40:0]   remx_ff [0:DivSteps-1];
   logic [40:0]   remy_ff [0:DivSteps-1];
   logic [16:0]   qx_ff   [0:DivSteps-1];
   logic [16:0]   qy_ff   [0:DivSteps-1];

   logic [32:0] adx, ady;

   assign adx = in_pair.dx[32] ? 33'(-in_pair.dx) : in_pair.dx;
   assign ady = in_pair.dy[32] ? 33'(-in_pair.dy) : in_pair.dy;

   // restoring division of |dx|<<16 and |dy|<<16 by d, one quotient bit per stage
   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      localparam int unsigned K = DivSteps - 1 - s;
      logic          vld_prev;
      cpcr_pair_type pair_prev;
      logic [24:0]   d_prev;
      logic [40:0]   remx_prev, remy_prev;
      logic [16:0]   qx_prev, qy_prev;
      logic [41:0]   dv;
      logic          takex, takey;

      if (s == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign pair_prev = in_pair;
         assign d_prev    = in_d;
         assign remx_prev = {adx[24:0], 16'b0};
         assign remy_prev = {ady[24:0], 16'b0};
         assign qx_prev   = '0;
         assign qy_prev   = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign pair_prev = pair_ff[s-1];
         assign d_prev    = d_ff[s-1];
         assign remx_prev = remx_ff[s-1];
         assign remy_prev = remy_ff[s-1];
         assign qx_prev   = qx_ff[s-1];
         assign qy_prev   = qy_ff[s-1];
      end

      assign dv    = 42'(d_prev) << K;
      assign takex = {1'b0, remx_prev} >= dv;
      assign takey = {1'b0, remy_prev} >= dv;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         pair_ff[s] <= pair_prev;
         d_ff[s]    <= d_prev;
         remx_ff[s] <= takex ? 41'({1'b0, remx_prev} - dv) : remx_prev;
         remy_ff[s] <= takey ? 41'({1'b0, remy_prev} - dv) : remy_prev;
         qx_ff[s]   <= takex ? (qx_prev | (17'd1 << K)) : qx_prev;
         qy_ff[s]   <= takey ? (qy_prev | (17'd1 << K)) : qy_prev;
      end
   end

   logic signed [17:0] qx_s, qy_s;
   cpcr_pair_type      last_pair;

   assign last_pair = pair_ff[DivSteps-1];
   assign qx_s = $signed({1'b0, qx_ff[DivSteps-1]});
   assign qy_s = $signed({1'b0, qy_ff[DivSteps-1]});

   always_comb begin
      if (d_ff[DivSteps-1] == '0) begin
         // coincident centres: push along +x
         out_nx = $signed(18'(OneQ16));
         out_ny = '0;
      end else begin
         out_nx = last_pair.dx[32] ? -qx_s : qx_s;
         out_ny = last_pair.dy[32] ? -qy_s : qy_s;
      end
   end

   assign out_vld  = vld_ff[DivSteps-1];
   assign out_pair = last_pair;
   assign out_d    = d_ff[DivSteps-1];

endmodule

// ===== rtl/core/cpcr_resolve.sv =====
module cpcr_resolve import cpcr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cpcr_cfg_type       cfg,
   input  logic               in_vld,
   input  cpcr_pair_type      in_pair,
   input  logic [24:0]        in_d,
   input  logic signed [17:0] in_nx,
   input  logic signed [17:0] in_ny,
   output logic               out_vld,
   output cpcr_pair_type      out_pair
);

   logic vld_ff [1:BackStages];
   cpcr_pair_type s1_pair_ff, s2_pair_ff, s3_pair_ff, s4_pair_ff, s5_pair_ff;
   cpcr_pair_type s6_pair_ff, s7_pair_ff, s8_pair_ff, s9_pair_ff;
   cpcr_pair_type s5_pair_in, s9_pair_in;

   logic signed [17:0] s1_nx_ff, s1_ny_ff, s2_nx_ff, s2_ny_ff, s3_nx_ff, s3_ny_ff;
   logic signed [17:0] s4_nx_ff, s4_ny_ff, s5_nx_ff, s5_ny_ff, s6_nx_ff, s6_ny_ff;
   logic [41:0]        s1_ovp_ff;
   logic signed [32:0] s1_rvx_ff, s1_rvy_ff;
   logic [25:0]        s2_corr_ff;
   logic signed [50:0] s2_pn1_ff, s2_pn2_ff, s2_pt1_ff, s2_pt2_ff;
   logic signed [44:0] s3_oxp_ff, s3_oyp_ff;
   logic signed [51:0] s3_sn_ff, s3_st_ff;
   logic signed [33:0] s4_pax_ff, s4_pay_ff, s4_pbx_ff, s4_pby_ff;
   logic signed [32:0] s4_hax_ff, s4_hay_ff, s4_hbx_ff, s4_hby_ff;
   logic signed [35:0] s4_rvn_ff, s4_rvt_ff;
   logic               s5_app_ff, s6_app_ff, s7_app_ff, s8_app_ff;
   logic [53:0]        s5_jp_ff;
   logic signed [52:0] s5_sp_ff;
   logic [30:0]        s6_jimp_ff;
   logic signed [31:0] s6_share_ff;
   logic signed [49:0] s7_jxp_ff, s7_jyp_ff, s7_nsp_ff, s7_xsp_ff;
   logic signed [34:0] s8_navx_ff, s8_navy_ff, s8_nbvx_ff, s8_nbvy_ff;

   logic [24:0]        overlap;
   logic [25:0]        ovq;
   logic [29:0]        half_max;
   logic signed [28:0] ox, oy;
   logic [35:0]        rvn_mag;
   logic [17:0]        rest_k;
   logic [36:0]        jq;
   logic signed [35:0] sq;
   logic signed [36:0] maxi_s;
   logic signed [33:0] jx, jy, tny, tnx;
   logic               elastic;

   assign overlap  = in_pair.rsum - in_d;
   assign ovq      = s1_ovp_ff[41:16];
   assign half_max = cfg.maxi[30:1];
   assign ox       = 29'(trunc_shr(64'(s3_oxp_ff), 16));
   assign oy       = 29'(trunc_shr(64'(s3_oyp_ff), 16));
   assign rvn_mag  = 36'(-s4_rvn_ff);
   assign rest_k   = 18'(OneQ16) + 18'(cfg.rest);
   assign jq       = s5_jp_ff[53:17];
   assign sq       = 36'(trunc_shr(64'(s5_sp_ff), 17));
   assign maxi_s   = $signed({6'b0, cfg.maxi});
   assign jx       = 34'(trunc_shr(64'(s7_jxp_ff), 16));
   assign jy       = 34'(trunc_shr(64'(s7_jyp_ff), 16));
   assign tny      = 34'(trunc_shr(64'(s7_nsp_ff), 16));
   assign tnx      = 34'(trunc_shr(64'(s7_xsp_ff), 16));
   assign elastic  = (cfg.rest != '0) || (cfg.xfer != '0);

   for (genvar s = 1; s <= BackStages; s++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (s == 1) begin
            vld_ff[s] <= in_vld;
         end else begin
            vld_ff[s] <= vld_ff[(s > 1) ? s - 1 : 1];
         end
      end
   end

   // clamp positions in place on a hit
   always_comb begin
      s5_pair_in = s4_pair_ff;
      if (s4_pair_ff.hit) begin
         s5_pair_in.ax = clamp_box(s4_pax_ff, s4_hax_ff, s4_pair_ff.ra);
         s5_pair_in.ay = clamp_box(s4_pay_ff, s4_hay_ff, s4_pair_ff.ra);
         s5_pair_in.bx = clamp_box(s4_pbx_ff, s4_hbx_ff, s4_pair_ff.rb);
         s5_pair_in.by = clamp_box(s4_pby_ff, s4_hby_ff, s4_pair_ff.rb);
      end
   end

   always_comb begin
      s9_pair_in = s8_pair_ff;
      if (s8_app_ff) begin
         s9_pair_in.avx = sat32(s8_navx_ff);
         s9_pair_in.avy = sat32(s8_navy_ff);
         s9_pair_in.bvx = sat32(s8_nbvx_ff);
         s9_pair_in.bvy = sat32(s8_nbvy_ff);
      end
   end

   always_ff @(posedge clock) begin
      // overlap correction product, relative velocity
      s1_pair_ff <= in_pair;
      s1_nx_ff   <= in_nx;
      s1_ny_ff   <= in_ny;
      s1_ovp_ff  <= 42'(overlap) * 42'(cfg.sep);
      s1_rvx_ff  <= 33'(in_pair.bvx) - 33'(in_pair.avx);
      s1_rvy_ff  <= 33'(in_pair.bvy) - 33'(in_pair.avy);

      // cap correction, project relative velocity
      s2_pair_ff <= s1_pair_ff;
      s2_nx_ff   <= s1_nx_ff;
      s2_ny_ff   <= s1_ny_ff;
      s2_corr_ff <= ({4'b0, ovq} > half_max) ? half_max[25:0] : ovq;
      s2_pn1_ff  <= 51'(s1_rvx_ff) * 51'(s1_nx_ff);
      s2_pn2_ff  <= 51'(s1_rvy_ff) * 51'(s1_ny_ff);
      s2_pt1_ff  <= 51'(s1_rvx_ff) * 51'(s1_ny_ff);
      s2_pt2_ff  <= 51'(s1_rvy_ff) * 51'(s1_nx_ff);

      s3_pair_ff <= s2_pair_ff;
      s3_nx_ff   <= s2_nx_ff;
      s3_ny_ff   <= s2_ny_ff;
      s3_oxp_ff  <= 45'(s2_nx_ff) * $signed({19'b0, s2_corr_ff});
      s3_oyp_ff  <= 45'(s2_ny_ff) * $signed({19'b0, s2_corr_ff});
      s3_sn_ff   <= 52'(s2_pn1_ff) + 52'(s2_pn2_ff);
      s3_st_ff   <= 52'(s2_pt2_ff) - 52'(s2_pt1_ff);

      // push apart, world bounds
      s4_pair_ff <= s3_pair_ff;
      s4_nx_ff   <= s3_nx_ff;
      s4_ny_ff   <= s3_ny_ff;
      s4_pax_ff  <= 34'(s3_pair_ff.ax) - 34'(ox);
      s4_pay_ff  <= 34'(s3_pair_ff.ay) - 34'(oy);
      s4_pbx_ff  <= 34'(s3_pair_ff.bx) + 34'(ox);
      s4_pby_ff  <= 34'(s3_pair_ff.by) + 34'(oy);
      s4_hax_ff  <= $signed({2'b0, cfg.width}) - $signed({9'b0, s3_pair_ff.ra});
      s4_hay_ff  <= $signed({2'b0, cfg.height}) - $signed({9'b0, s3_pair_ff.ra});
      s4_hbx_ff  <= $signed({2'b0, cfg.width}) - $signed({9'b0, s3_pair_ff.rb});
      s4_hby_ff  <= $signed({2'b0, cfg.height}) - $signed({9'b0, s3_pair_ff.rb});
      s4_rvn_ff  <= 36'(trunc_shr(64'(s3_sn_ff), 16));
      s4_rvt_ff  <= 36'(trunc_shr(64'(s3_st_ff), 16));

      // impulse and share products
      s5_pair_ff <= s5_pair_in;
      s5_nx_ff  <= s4_nx_ff;
      s5_ny_ff  <= s4_ny_ff;
      s5_app_ff <= s4_rvn_ff[35];
      s5_jp_ff  <= 54'(rest_k) * 54'(rvn_mag);
      s5_sp_ff  <= 53'(s4_rvt_ff) * $signed({36'b0, cfg.xfer});

      // limit both to max_impulse
      s6_pair_ff  <= s5_pair_ff;
      s6_nx_ff    <= s5_nx_ff;
      s6_ny_ff    <= s5_ny_ff;
      s6_app_ff   <= s5_app_ff;
      s6_jimp_ff  <= (jq > {6'b0, cfg.maxi}) ? cfg.maxi : jq[30:0];
      if (37'(sq) > maxi_s) begin
         s6_share_ff <= 32'(maxi_s);
      end else if (37'(sq) < -maxi_s) begin
         s6_share_ff <= 32'(-maxi_s);
      end else begin
         s6_share_ff <= 32'(sq);
      end

      s7_pair_ff <= s6_pair_ff;
      s7_app_ff  <= s6_app_ff;
      s7_jxp_ff  <= 50'(s6_nx_ff) * $signed({19'b0, s6_jimp_ff});
      s7_jyp_ff  <= 50'(s6_ny_ff) * $signed({19'b0, s6_jimp_ff});
      s7_nsp_ff  <= 50'(s6_ny_ff) * 50'(s6_share_ff);
      s7_xsp_ff  <= 50'(s6_nx_ff) * 50'(s6_share_ff);

      // tangent is (-ny, nx)
      s8_pair_ff <= s7_pair_ff;
      s8_app_ff  <= s7_app_ff && s7_pair_ff.hit && elastic;
      s8_navx_ff <= 35'(s7_pair_ff.avx) - 35'(jx) - 35'(tny);
      s8_navy_ff <= 35'(s7_pair_ff.avy) - 35'(jy) + 35'(tnx);
      s8_nbvx_ff <= 35'(s7_pair_ff.bvx) + 35'(jx) + 35'(tny);
      s8_nbvy_ff <= 35'(s7_pair_ff.bvy) + 35'(jy) - 35'(tnx);

      s9_pair_ff <= s9_pair_in;
   end

   assign out_vld  = vld_ff[BackStages];
   assign out_pair = s9_pair_ff;

endmodule

// ===== rtl/core/circle_pair_collision_resolve_unit.sv =====
// Resolves one pair of equal-mass circles per clock: a request is taken on every cycle that
// start is high outside reset (busy is high only during reset), and its result appears on the
// rsp_ ports for one cycle, marked by rsp_valid, after the front stages, the 25-stage square
// root of the squared distance, the 17-stage divider that forms the unit normal and the
// resolve stages. Results cannot be held off; capture them in the cycle rsp_valid is high.
// Write the csr_ registers only while no request is in flight.
module circle_pair_collision_resolve_unit import cpcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_first_x,
   input  logic [31:0] req_first_y,
   input  logic [31:0] req_second_x,
   input  logic [31:0] req_second_y,
   input  logic [23:0] req_first_radius,
   input  logic [23:0] req_second_radius,
   input  logic [31:0] req_first_vx,
   input  logic [31:0] req_first_vy,
   input  logic [31:0] req_second_vx,
   input  logic [31:0] req_second_vy,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_first_x,
   output logic [31:0] rsp_new_first_y,
   output logic [31:0] rsp_new_second_x,
   output logic [31:0] rsp_new_second_y,
   output logic [31:0] rsp_new_first_vx,
   output logic [31:0] rsp_new_first_vy,
   output logic [31:0] rsp_new_second_vx,
   output logic [31:0] rsp_new_second_vy,
   output logic        rsp_collided,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   logic [16:0]   sep_ff, rest_ff, xfer_ff;
   logic [30:0]   maxi_ff, width_ff, height_ff;
   cpcr_cfg_type  cfg;
   cpcr_pair_type req_pair;
   logic          accept;

   logic          fr_vld, sq_vld, dv_vld, rs_vld;
   cpcr_pair_type fr_pair, sq_pair, dv_pair, rs_pair;
   logic [49:0]   fr_d2;
   logic [24:0]   sq_d, dv_d;
   logic signed [17:0] dv_nx, dv_ny;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff    <= OneQ16;
         rest_ff   <= '0;
         xfer_ff   <= '0;
         maxi_ff   <= 31'd65536;
         width_ff  <= 31'd67108864;
         height_ff <= 31'd67108864;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SEP:    sep_ff    <= csr_wdata[16:0];
            CSR_REST:   rest_ff   <= csr_wdata[16:0];
            CSR_XFER:   xfer_ff   <= csr_wdata[16:0];
            CSR_MAXI:   maxi_ff   <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gains above one act as one
   always_comb begin
      cfg.sep    = (sep_ff > OneQ16) ? OneQ16 : sep_ff;
      cfg.rest   = (rest_ff > OneQ16) ? OneQ16 : rest_ff;
      cfg.xfer   = (xfer_ff > OneQ16) ? OneQ16 : xfer_ff;
      cfg.maxi   = maxi_ff;
      cfg.width  = width_ff;
      cfg.height = height_ff;
   end

   always_comb begin
      req_pair      = '0;
      req_pair.ax   = req_first_x;
      req_pair.ay   = req_first_y;
      req_pair.bx   = req_second_x;
      req_pair.by   = req_second_y;
      req_pair.ra   = req_first_radius;
      req_pair.rb   = req_second_radius;
      req_pair.avx  = req_first_vx;
      req_pair.avy  = req_first_vy;
      req_pair.bvx  = req_second_vx;
      req_pair.bvy  = req_second_vy;
   end

   cpcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (accept),
      .in_pair  (req_pair),
      .out_vld  (fr_vld),
      .out_pair (fr_pair),
      .out_d2   (fr_d2)
   );

   cpcr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (fr_vld),
      .in_pair  (fr_pair),
      .in_d2    (fr_d2),
      .out_vld  (sq_vld),
      .out_pair (sq_pair),
      .out_d    (sq_d)
   );

   cpcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (sq_vld),
      .in_pair  (sq_pair),
      .in_d     (sq_d),
      .out_vld  (dv_vld),
      .out_pair (dv_pair),
      .out_d    (dv_d),
      .out_nx   (dv_nx),
      .out_ny   (dv_ny)
   );

   cpcr_resolve u_resolve (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_vld   (dv_vld),
      .in_pair  (dv_pair),
      .in_d     (dv_d),
      .in_nx    (dv_nx),
      .in_ny    (dv_ny),
      .out_vld  (rs_vld),
      .out_pair (rs_pair)
   );

   assign rsp_valid         = rs_vld;
   assign rsp_new_first_x   = rs_pair.ax;
   assign rsp_new_first_y   = rs_pair.ay;
   assign rsp_new_second_x  = rs_pair.bx;
   assign rsp_new_second_y  = rs_pair.by;
   assign rsp_new_first_vx  = rs_pair.avx;
   assign rsp_new_first_vy  = rs_pair.avy;
   assign rsp_new_second_vx = rs_pair.bvx;
   assign rsp_new_second_vy = rs_pair.bvy;
   assign rsp_collided      = rs_pair.hit;

`ifndef NO_ASSERTIONS
   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("result without a matching request");

   a_miss_passes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_collided |->
         rsp_new_first_x == $past(req_first_x, Latency) &&
         rsp_new_second_vy == $past(req_second_vy, Latency))
      else $error("non-overlapping pair was modified");

   a_hit_in_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_collided |->
         $signed(rsp_new_first_x) >= $signed({8'b0, $past(req_first_radius, Latency)}))
      else $error("resolved position below its radius bound");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench import cpcr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint OneQ = 65536;
   localparam int unsigned CycleLimit = 400000;

   typedef struct {
      logic [31:0] ax, ay, bx, by;
      logic [23:0] ra, rb;
      logic [31:0] avx, avy, bvx, bvy;
   } circle_pair_type;

   typedef struct {
      logic [31:0] ax, ay, bx, by, avx, avy, bvx, bvy;
      logic        hit;
   } resolved_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_first_x = '0, req_first_y = '0, req_second_x = '0, req_second_y = '0;
   logic [23:0] req_first_radius = '0, req_second_radius = '0;
   logic [31:0] req_first_vx = '0, req_first_vy = '0, req_second_vx = '0, req_second_vy = '0;
   logic        rsp_valid;
   logic [31:0] rsp_new_first_x, rsp_new_first_y, rsp_new_second_x, rsp_new_second_y;
   logic [31:0] rsp_new_first_vx, rsp_new_first_vy, rsp_new_second_vx, rsp_new_second_vy;
   logic        rsp_collided;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [30:0] csr_wdata = '0;

   circle_pair_collision_resolve_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register copies used by the predictor
   longint sep_gain, rest_coef, xfer_frac, max_imp, world_w, world_h;

   circle_pair_type   pending[$];
   resolved_pair_type resolved_q[$];
   int unsigned    errors = 0, cycles = 0, requests = 0, results = 0, collisions = 0;
   bit             calm = 1'b0;

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint limit(longint v, longint lo, longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   function automatic logic [31:0] sat_word(longint v);
      longint s;
      s = limit(v, -64'sd2147483648, 64'sd2147483647);
      return s[31:0];
   endfunction

   function automatic resolved_pair_type resolve_pair(circle_pair_type p);
      resolved_pair_type r;
      longint ax, ay, bx, by, ra, rb, avx, avy, bvx, bvy, dx, dy, rsum;
      longint sep, rest, xfer, nx, ny, d, corr, ox, oy;
      longint rvx, rvy, rvn, jimp, jx, jy, tx, ty, rvt, share, sx, sy;
      longint unsigned d2;
      bit hit;
      ax = longint'($signed(p.ax)); ay = longint'($signed(p.ay));
      bx = longint'($signed(p.bx)); by = longint'($signed(p.by));
      ra = longint'(p.ra); rb = longint'(p.rb);
      avx = longint'($signed(p.avx)); avy = longint'($signed(p.avy));
      bvx = longint'($signed(p.bvx)); bvy = longint'($signed(p.bvy));
      dx = bx - ax; dy = by - ay;
      rsum = ra + rb;
      sep = sep_gain > OneQ ? OneQ : sep_gain;
      rest = rest_coef > OneQ ? OneQ : rest_coef;
      xfer = xfer_frac > OneQ ? OneQ : xfer_frac;
      hit = 1'b0;
      d2 = 0;
      if ((dx < 0 ? -dx : dx) < rsum && (dy < 0 ? -dy : dy) < rsum) begin
         d2 = longint'(dx * dx) + longint'(dy * dy);
         hit = d2 < longint'(rsum * rsum);
      end
      if (hit) begin
         d = longint'(floor_root(d2));
         if (d > 0) begin
            nx = limit((dx * OneQ) / d, -OneQ, OneQ);
            ny = limit((dy * OneQ) / d, -OneQ, OneQ);
         end else begin
            nx = OneQ;
            ny = 0;
         end
         corr = ((rsum - d) * sep) / OneQ;
         if (corr > max_imp / 2) corr = max_imp / 2;
         ox = (nx * corr) / OneQ;
         oy = (ny * corr) / OneQ;
         ax -= ox; ay -= oy; bx += ox; by += oy;
         // lower bound wins on an inverted box
         ax = limit(ax, ra, world_w - ra); if (ax < ra) ax = ra;
         ay = limit(ay, ra, world_h - ra); if (ay < ra) ay = ra;
         bx = limit(bx, rb, world_w - rb); if (bx < rb) bx = rb;
         by = limit(by, rb, world_h - rb); if (by < rb) by = rb;
         if (rest > 0 || xfer > 0) begin
            rvx = bvx - avx; rvy = bvy - avy;
            rvn = (rvx * nx + rvy * ny) / OneQ;
            if (rvn < 0) begin
               jimp = limit(-((OneQ + rest) * rvn) / (2 * OneQ), -max_imp, max_imp);
               jx = (nx * jimp) / OneQ; jy = (ny * jimp) / OneQ;
               avx -= jx; avy -= jy; bvx += jx; bvy += jy;
               if (xfer > 0) begin
                  tx = -ny; ty = nx;
                  rvt = (rvx * tx + rvy * ty) / OneQ;
                  share = limit((rvt * xfer) / (2 * OneQ), -max_imp, max_imp);
                  sx = (tx * share) / OneQ; sy = (ty * share) / OneQ;
                  avx += sx; avy += sy; bvx -= sx; bvy -= sy;
               end
            end
         end
      end
      r.ax = ax[31:0]; r.ay = ay[31:0]; r.bx = bx[31:0]; r.by = by[31:0];
      r.avx = sat_word(avx); r.avy = sat_word(avy);
      r.bvx = sat_word(bvx); r.bvy = sat_word(bvy);
      r.hit = hit;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endfunction

   // driver: present the head request at the falling edge, idle at random unless calm is set
   always @(negedge clock) begin
      if (!reset && pending.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
         start <= 1'b1;
         req_first_x <= pending[0].ax;
         req_first_y <= pending[0].ay;
         req_second_x <= pending[0].bx;
         req_second_y <= pending[0].by;
         req_first_radius <= pending[0].ra;
         req_second_radius <= pending[0].rb;
         req_first_vx <= pending[0].avx;
         req_first_vy <= pending[0].avy;
         req_second_vx <= pending[0].bvx;
         req_second_vy <= pending[0].bvy;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: track registers, predict accepted requests, check results
   always @(posedge clock) begin
      resolved_pair_type e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_SEP:    sep_gain = longint'(csr_wdata[16:0]);
               CSR_REST:   rest_coef = longint'(csr_wdata[16:0]);
               CSR_XFER:   xfer_frac = longint'(csr_wdata[16:0]);
               CSR_MAXI:   max_imp = longint'(csr_wdata);
               CSR_WIDTH:  world_w = longint'(csr_wdata);
               CSR_HEIGHT: world_h = longint'(csr_wdata);
               default: ;
            endcase
         end
         if (start && !busy) begin
            resolved_q.push_back(resolve_pair(pending.pop_front()));
            requests++;
         end
         if (rsp_valid) begin
            results++;
            if (resolved_q.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               e = resolved_q.pop_front();
               if (e.hit) collisions++;
               check_field("new_first_x", e.ax, rsp_new_first_x);
               check_field("new_first_y", e.ay, rsp_new_first_y);
               check_field("new_second_x", e.bx, rsp_new_second_x);
               check_field("new_second_y", e.by, rsp_new_second_y);
               check_field("new_first_vx", e.avx, rsp_new_first_vx);
               check_field("new_first_vy", e.avy, rsp_new_first_vy);
               check_field("new_second_vx", e.bvx, rsp_new_second_vx);
               check_field("new_second_vy", e.bvy, rsp_new_second_vy);
               check_field("collided", 32'(e.hit), 32'(rsp_collided));
            end
         end
      end
   end

   task automatic write_reg(cpcr_csr_type idx, logic [30:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(logic [30:0] s, logic [30:0] r, logic [30:0] x,
                            logic [30:0] m, logic [30:0] w, logic [30:0] h);
      write_reg(CSR_SEP, s);
      write_reg(CSR_REST, r);
      write_reg(CSR_XFER, x);
      write_reg(CSR_MAXI, m);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   task automatic drain();
      while (pending.size() != 0 || resolved_q.size() != 0) @(posedge clock);
      repeat (Latency + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] vel(bit wide);
      return wide ? $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
   endfunction

   function automatic circle_pair_type make_pair(int unsigned kind);
      circle_pair_type p;
      int unsigned rs;
      longint dx, dy;
      bit wide;
      wide = $urandom_range(9) == 0;
      p.avx = vel(wide); p.avy = vel(wide); p.bvx = vel(wide); p.bvy = vel(wide);
      if (kind == 0) begin
         // noise: any value of every position and radius field
         p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
         p.ra = $urandom; p.rb = $urandom;
      end else begin
         if ($urandom_range(19) == 0) begin
            p.ra = $urandom; p.rb = $urandom;
         end else begin
            p.ra = $urandom_range(0, 1 << 21); p.rb = $urandom_range(1, 1 << 21);
         end
         rs = p.ra + p.rb;
         dx = $urandom_range(0, rs - 1); dy = $urandom_range(0, rs - 1);
         if ($urandom_range(1)) dx = -dx;
         if ($urandom_range(1)) dy = -dy;
         if ($urandom_range(15) == 0) begin
            dx = 0; dy = 0;
         end
         p.ax = $urandom_range(0, 1 << 27);
         p.ay = $urandom_range(0, 1 << 27);
         if ($urandom_range(9) == 0) p.ax = $urandom;
         p.bx = p.ax + 32'(dx);
         p.by = p.ay + 32'(dy);
      end
      return p;
   endfunction

   function automatic circle_pair_type pair_of(longint ax, longint ay, longint bx, longint by,
                                               longint ra, longint rb, longint avx,
                                               longint avy, longint bvx, longint bvy);
      circle_pair_type p;
      p.ax = ax[31:0]; p.ay = ay[31:0]; p.bx = bx[31:0]; p.by = by[31:0];
      p.ra = ra[23:0]; p.rb = rb[23:0];
      p.avx = avx[31:0]; p.avy = avy[31:0]; p.bvx = bvx[31:0]; p.bvy = bvy[31:0];
      return p;
   endfunction

   task automatic run_random(int unsigned count);
      repeat (count) begin
         pending.push_back(make_pair($urandom_range(9) < 8 ? 1 : 0));
         if (pending.size() > 64) begin
            while (pending.size() >= 32) @(posedge clock);
         end
      end
      drain();
   endtask

   initial begin
      sep_gain = 65536; rest_coef = 0; xfer_frac = 0;
      max_imp = 65536; world_w = 67108864; world_h = 67108864;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults first, then every register at full scale
      pending.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending.push_back(pair_of(100 << 16, 100 << 16, 100 << 16, 100 << 16,
                                5 << 16, 5 << 16, 65536, 0, -65536, 0));
      pending.push_back(pair_of(100 << 16, 100 << 16, 120 << 16, 100 << 16,
                                5 << 16, 5 << 16, 0, 0, 0, 0));
      pending.push_back(pair_of(100 << 16, 100 << 16, 108 << 16, 103 << 16,
                                5 << 16, 5 << 16, 0, 0, 0, 0));
      drain();
      write_all(65536, 65536, 65536, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
      // head-on approach, separating pair, resting pair, saturating velocities, extreme corners and radii
      pending.push_back(pair_of(200 << 16, 200 << 16, 206 << 16, 200 << 16,
                                4 << 16, 4 << 16, 3 << 16, 0, -(3 << 16), 0));
      pending.push_back(pair_of(200 << 16, 200 << 16, 206 << 16, 202 << 16,
                                4 << 16, 4 << 16, -(3 << 16), 0, 3 << 16, 0));
      pending.push_back(pair_of(200 << 16, 200 << 16, 206 << 16, 200 << 16,
                                4 << 16, 4 << 16, 7, 7, 7, 7));
      pending.push_back(pair_of(200 << 16, 200 << 16, 201 << 16, 201 << 16,
                                4 << 16, 4 << 16, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                -64'sd2147483648, -64'sd2147483648));
      pending.push_back(pair_of(-64'sd2147483648, -64'sd2147483648, -64'sd2147483640,
                                -64'sd2147483648, 24'hff_ffff, 24'hff_ffff,
                                32'sh7fff_ffff, 0, -64'sd2147483648, 0));
      pending.push_back(pair_of(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                                64'sd2147483647, 24'hff_ffff, 24'hff_ffff, 0, 0, 0, 0));
      pending.push_back(pair_of(0, 0, 24'hff_ffff, 0, 24'hff_ffff, 1, 0, 0, 0, 0));
      pending.push_back(pair_of(0, 0, 2 * 24'hff_ffff, 0, 24'hff_ffff, 24'hff_ffff,
                                0, 0, 0, 0));
      calm = 1'b1;
      run_random(260);
      calm = 1'b0;

      // zero separation gain with an over-range restitution, zero cap and an inverted box
      write_all(0, 31'h1_ffff, 30000, 0, 0, 100);
      write_reg(cpcr_csr_type'(3'd6), 31'h7fff_ffff);
      write_reg(cpcr_csr_type'(3'd7), 31'h0);
      pending.push_back(pair_of(50 << 16, 50 << 16, 52 << 16, 51 << 16,
                                3 << 16, 3 << 16, 2 << 16, 0, -(2 << 16), 1 << 16));
      pending.push_back(pair_of(50 << 16, 50 << 16, 50 << 16, 50 << 16,
                                3 << 16, 0, 0, 1 << 16, 0, -(1 << 16)));
      run_random(250);

      write_all(31'h1_ffff, 0, 31'h1_ffff, 1 << 20, 1 << 24, 1 << 26);
      run_random(250);
      write_all(32768, 20000, 0, 31'h7fff_ffff, 10 << 16, 31'h7fff_ffff);
      run_random(250);
      repeat (2) begin
         write_all($urandom_range(0, 31'h1_ffff), $urandom_range(0, 31'h1_ffff),
                   $urandom_range(0, 31'h1_ffff), $urandom_range(0, 1 << 22),
                   $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 28));
         run_random(260);
      end
      drain();

      $display("Resolved %0d circle pairs (%0d overlapping) over seven register settings.",
               results, collisions);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
